>>> design/kt2d_pkg.sv
// ----------------------------------------------------------------------------
// kt2d_pkg
// Shared types, constants and saturation helpers for the 2D tracker.
// ----------------------------------------------------------------------------
package kt2d_pkg;

  // Command codes carried by the input beat.
  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_FOLLOW = 2'd1,
    CMD_INIT   = 2'd2
  } cmd_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PROC_NOISE = 2'd0;
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd1;
  localparam logic [1:0] CFG_INIT_COV   = 2'd2;

  localparam logic [30:0] PROC_NOISE_RST = 31'd13107;
  localparam logic [30:0] MEAS_NOISE_RST = 31'd1310720;
  localparam logic [30:0] INIT_COV_RST   = 31'd327680;

  // Regions of the scratch memory, 16 entries each.
  localparam logic [1:0] RG_P  = 2'd0;
  localparam logic [1:0] RG_AP = 2'd1;
  localparam logic [1:0] RG_PP = 2'd2;
  localparam logic [1:0] RG_K  = 2'd3;

  // Request to the shared multiply / divide unit.
  typedef struct packed {
    logic go;
    logic is_div;
    logic neg_a;
  } md_req_t;

  function automatic logic signed [47:0] sx40(input logic signed [39:0] a);
    return {{8{a[39]}}, a};
  endfunction

  function automatic logic signed [47:0] sx32(input logic signed [31:0] a);
    return {{16{a[31]}}, a};
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    logic signed [39:0] r;
    if (v > 48'sh007F_FFFF_FFFF) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < 48'shFF80_0000_0000) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 48'shFFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> design/kt2d_if.sv
// ----------------------------------------------------------------------------
// kt2d_if
// Valid / ready channels for measurement beats and estimate beats.
// ----------------------------------------------------------------------------
interface kt2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, command, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, command, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface kt2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_pos_x;
  logic signed [31:0] est_pos_y;
  logic signed [31:0] est_vel_x;
  logic signed [31:0] est_vel_y;

  modport source (output valid, est_pos_x, est_pos_y, est_vel_x, est_vel_y, input ready);
  modport sink   (input valid, est_pos_x, est_pos_y, est_vel_x, est_vel_y, output ready);
endinterface

>>> design/kt2d_muldiv.sv
// ----------------------------------------------------------------------------
// kt2d_muldiv
// Shared Q16.16 multiplier (four 20x20 partial products) and bit-serial divider.
// ----------------------------------------------------------------------------
module kt2d_muldiv (
  input  logic                clk,
  input  logic                rst_n,
  input  kt2d_pkg::md_req_t   req,
  input  logic signed [39:0]  op_a,
  input  logic signed [39:0]  op_b,
  output logic                done,
  output logic signed [39:0]  res
);

  localparam int DivSteps = 56;

  logic        busy_r, done_r, div_r, neg_r;
  logic [5:0]  cnt_r;
  logic [39:0] ua_r, ub_r, prod_r, hh_r, low_r;
  logic [40:0] mid_r, rem_r;
  logic [55:0] quo_r;
  logic signed [39:0] res_r;

  logic [39:0] mag_a, mag_b, prod;
  logic [19:0] mul_x, mul_y;
  logic [40:0] low_rnd, rs, rem_n;
  logic [47:0] m;
  logic [55:0] mv;
  logic        ge;
  logic signed [39:0] res_v;

  assign mag_a = op_a[39] ? (~op_a + 40'd1) : op_a;
  assign mag_b = op_b[39] ? (~op_b + 40'd1) : op_b;

  // Partial product order: high*high, high*low, low*high, low*low.
  assign mul_x = cnt_r[1] ? ua_r[19:0] : ua_r[39:20];
  assign mul_y = cnt_r[0] ? ub_r[19:0] : ub_r[39:20];
  assign prod  = {20'd0, mul_x} * {20'd0, mul_y};

  assign rs    = {rem_r[39:0], quo_r[55]};
  assign ge    = rs >= {1'b0, ub_r};
  assign rem_n = ge ? (rs - {1'b0, ub_r}) : rs;

  always_comb begin
    low_rnd = {1'b0, low_r} + 41'd32768;
    if (hh_r >= 40'd32768) begin
      m = 48'h0100_0000_0000;
    end else begin
      m = {9'd0, hh_r[14:0], 24'd0} + {3'd0, mid_r, 4'd0} + {23'd0, low_rnd[40:16]};
    end
    mv = div_r ? quo_r : {8'd0, m};
    if (neg_r) begin
      res_v = (mv > 56'h00_0080_0000_0000) ? 40'sh80_0000_0000 : (~mv[39:0] + 40'd1);
    end else begin
      res_v = (mv > 56'h00_007F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF : mv[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if ((div_r && cnt_r == 6'(DivSteps)) || (!div_r && cnt_r == 6'd5)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      div_r <= req.is_div;
      neg_r <= req.is_div ? (op_a[39] ^ req.neg_a) : (op_a[39] ^ op_b[39]);
      ua_r  <= mag_a;
      ub_r  <= mag_b;
      cnt_r <= 6'd0;
      rem_r <= 41'd0;
      quo_r <= {mag_a, 16'd0};
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 6'd1;
      prod_r <= prod;
      if (div_r) begin
        if (cnt_r == 6'(DivSteps)) begin
          res_r <= res_v;
        end else begin
          rem_r <= rem_n;
          quo_r <= {quo_r[54:0], ge};
        end
      end else begin
        case (cnt_r)
          6'd1:    hh_r  <= prod_r;
          6'd2:    mid_r <= {1'b0, prod_r};
          6'd3:    mid_r <= mid_r + {1'b0, prod_r};
          6'd4:    low_r <= prod_r;
          6'd5:    res_r <= res_v;
          default: ;
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> design/kalman_tracker_2d_const_velocity_core.sv
// ----------------------------------------------------------------------------
// kalman_tracker_2d_const_velocity_core
// Four-state constant-velocity Kalman tracker in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each input beat carries a command (update, follow or init) and a position,
// and each produces exactly one output beat with the state estimate. The 4x4
// covariance and all matrix intermediates live in a 64-entry scratch memory
// with two registered read ports and one write port; a sequencer walks that
// memory entry by entry and feeds one shared multiply / divide unit. An update
// or follow beat that seeds the track first writes the 16 covariance entries;
// the four divisions by the determinant and the 58 Q16.16 multiplies through
// the single shared unit dominate the work of an update or follow beat. When
// the determinant is not positive the correction is skipped. A new beat is
// accepted only while the sequencer is idle; a finished estimate may wait in
// the output register while the next beat is taken. No clearing pass is
// needed after reset, since the covariance is always seeded before it is read.
module kalman_tracker_2d_const_velocity_core (
  input  logic              clk,
  input  logic              rst_n,
  kt2d_in_if.sink           in_ch,
  kt2d_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  // One-hot sequencer states.
  typedef enum logic [24:0] {
    S_IDLE   = 25'd1,
    S_SEED   = 25'd2,
    S_PRED   = 25'd4,
    S_AP_RD  = 25'd8,
    S_AP_WR  = 25'd16,
    S_PP_RD  = 25'd32,
    S_PP_WR  = 25'd64,
    S_S_RD   = 25'd128,
    S_S_RD2  = 25'd256,
    S_S_CAP  = 25'd512,
    S_DET    = 25'd1024,
    S_INV    = 25'd2048,
    S_K_RD   = 25'd4096,
    S_K_MUL  = 25'd8192,
    S_X_RD   = 25'd16384,
    S_X_MUL  = 25'd32768,
    S_NP_RD1 = 25'd65536,
    S_NP_M1  = 25'd131072,
    S_NP_RD2 = 25'd262144,
    S_NP_M2  = 25'd524288,
    S_NP_RD3 = 25'd1048576,
    S_NP_WR  = 25'd2097152,
    S_CPY_RD = 25'd4194304,
    S_CPY_WR = 25'd8388608,
    S_DONE   = 25'd16777216
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] e_r, e_nxt;
  logic [1:0] u_r, u_nxt;
  logic       md_busy_r, md_busy_nxt;
  logic       init_r, init_nxt;
  logic       seed_upd_r, seed_upd_nxt;
  logic [30:0] pn_r, pn_nxt, mn_r, mn_nxt, ic_r, ic_nxt;
  logic signed [31:0] x_r [4];
  logic signed [31:0] x_nxt [4];
  logic signed [31:0] lm0_r, lm0_nxt, lm1_r, lm1_nxt;
  logic signed [39:0] s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic signed [39:0] det_r, det_nxt;
  logic signed [39:0] inv0_r, inv0_nxt, inv1_r, inv1_nxt;
  logic signed [39:0] inv2_r, inv2_nxt, inv3_r, inv3_nxt;
  logic signed [39:0] t_r, t_nxt, t2_r, t2_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic signed [31:0] opx_r, opx_nxt, opy_r, opy_nxt, ovx_r, ovx_nxt, ovy_r, ovy_nxt;

  // Scratch memory: covariance, A*P, predicted P and gain regions.
  logic signed [39:0] mem [64];
  logic signed [39:0] rd_a_r, rd_b_r;
  logic               mem_we, mem_re;
  logic [5:0]         mem_wa, ra, rb;
  logic signed [39:0] mem_wd;

  kt2d_pkg::md_req_t  md_req;
  logic signed [39:0] md_a, md_b, md_res;
  logic               md_done, md_state, in_acc;

  kt2d_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (md_a),
    .op_b  (md_b),
    .done  (md_done),
    .res   (md_res)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign md_state = (state_r == S_DET) || (state_r == S_INV) || (state_r == S_K_MUL) ||
                    (state_r == S_X_MUL) || (state_r == S_NP_M1) || (state_r == S_NP_M2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_comb begin
    logic signed [39:0] det_v;
    logic signed [47:0] v48;

    state_nxt = state_r;  e_nxt = e_r;  u_nxt = u_r;
    md_busy_nxt = md_busy_r;  init_nxt = init_r;  seed_upd_nxt = seed_upd_r;
    pn_nxt = pn_r;  mn_nxt = mn_r;  ic_nxt = ic_r;
    for (int k = 0; k < 4; k++) x_nxt[k] = x_r[k];
    lm0_nxt = lm0_r;  lm1_nxt = lm1_r;
    s0_nxt = s0_r;  s1_nxt = s1_r;  s2_nxt = s2_r;  s3_nxt = s3_r;
    det_nxt = det_r;
    inv0_nxt = inv0_r;  inv1_nxt = inv1_r;  inv2_nxt = inv2_r;  inv3_nxt = inv3_r;
    t_nxt = t_r;  t2_nxt = t2_r;  y0_nxt = y0_r;  y1_nxt = y1_r;
    out_valid_nxt = out_valid_r;
    opx_nxt = opx_r;  opy_nxt = opy_r;  ovx_nxt = ovx_r;  ovy_nxt = ovy_r;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;
    mem_re = 1'b0;  ra = '0;  rb = '0;
    md_a = '0;  md_b = '0;
    md_req.go = md_state && !md_busy_r;
    md_req.is_div = (state_r == S_INV);
    md_req.neg_a = 1'b0;
    det_v = '0;
    v48 = '0;

    if (md_req.go) begin
      md_busy_nxt = 1'b1;
    end
    if (md_done) begin
      md_busy_nxt = 1'b0;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        kt2d_pkg::CFG_PROC_NOISE: pn_nxt = cfg_data;
        kt2d_pkg::CFG_MEAS_NOISE: mn_nxt = cfg_data;
        kt2d_pkg::CFG_INIT_COV:   ic_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        e_nxt = 4'd0;
        u_nxt = 2'd0;
        if (in_acc) begin
          case (in_ch.command)
            kt2d_pkg::CMD_INIT: begin
              x_nxt[0] = in_ch.pos_x;  x_nxt[1] = in_ch.pos_y;
              x_nxt[2] = in_ch.vel_x;  x_nxt[3] = in_ch.vel_y;
              init_nxt = 1'b1;
              seed_upd_nxt = 1'b0;
              state_nxt = S_SEED;
            end
            kt2d_pkg::CMD_UPDATE, kt2d_pkg::CMD_FOLLOW: begin
              lm0_nxt = in_ch.pos_x;
              lm1_nxt = in_ch.pos_y;
              if (!init_r) begin
                // First update or follow beat seeds position with zero velocity.
                x_nxt[0] = in_ch.pos_x;  x_nxt[1] = in_ch.pos_y;
                x_nxt[2] = '0;           x_nxt[3] = '0;
                init_nxt = 1'b1;
                seed_upd_nxt = 1'b1;
                state_nxt = S_SEED;
              end else begin
                if (in_ch.command == kt2d_pkg::CMD_FOLLOW) begin
                  x_nxt[0] = lm0_r;
                  x_nxt[1] = lm1_r;
                  x_nxt[2] = kt2d_pkg::sat32(kt2d_pkg::sx32(in_ch.pos_x) -
                                             kt2d_pkg::sx32(lm0_r));
                  x_nxt[3] = kt2d_pkg::sat32(kt2d_pkg::sx32(in_ch.pos_y) -
                                             kt2d_pkg::sx32(lm1_r));
                end
                state_nxt = S_PRED;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SEED: begin
        mem_we = 1'b1;
        mem_wa = {kt2d_pkg::RG_P, e_r};
        mem_wd = (e_r[3:2] == e_r[1:0]) ? {9'd0, ic_r} : '0;
        e_nxt  = e_r + 4'd1;
        if (e_r == 4'd15) begin
          state_nxt = seed_upd_r ? S_PRED : S_DONE;
        end
      end

      S_PRED: begin
        x_nxt[0] = kt2d_pkg::sat32(kt2d_pkg::sx32(x_r[0]) + kt2d_pkg::sx32(x_r[2]));
        x_nxt[1] = kt2d_pkg::sat32(kt2d_pkg::sx32(x_r[1]) + kt2d_pkg::sx32(x_r[3]));
        e_nxt = 4'd0;
        state_nxt = S_AP_RD;
      end

      S_AP_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_P, e_r};
        rb = {kt2d_pkg::RG_P, 1'b1, e_r[2:0]};
        state_nxt = S_AP_WR;
      end

      S_AP_WR: begin
        mem_we = 1'b1;
        mem_wa = {kt2d_pkg::RG_AP, e_r};
        mem_wd = e_r[3] ? rd_a_r :
                 kt2d_pkg::sat40(kt2d_pkg::sx40(rd_a_r) + kt2d_pkg::sx40(rd_b_r));
        e_nxt = e_r + 4'd1;
        state_nxt = (e_r == 4'd15) ? S_PP_RD : S_AP_RD;
      end

      S_PP_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_AP, e_r};
        rb = {kt2d_pkg::RG_AP, e_r[3:2], 1'b1, e_r[0]};
        state_nxt = S_PP_WR;
      end

      S_PP_WR: begin
        det_v = e_r[1] ? rd_a_r :
                kt2d_pkg::sat40(kt2d_pkg::sx40(rd_a_r) + kt2d_pkg::sx40(rd_b_r));
        if (e_r[3:2] == e_r[1:0]) begin
          det_v = kt2d_pkg::sat40(kt2d_pkg::sx40(det_v) + {17'd0, pn_r});
        end
        mem_we = 1'b1;
        mem_wa = {kt2d_pkg::RG_PP, e_r};
        mem_wd = det_v;
        e_nxt = e_r + 4'd1;
        state_nxt = (e_r == 4'd15) ? S_S_RD : S_PP_RD;
      end

      S_S_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_PP, 4'd0};
        rb = {kt2d_pkg::RG_PP, 4'd5};
        state_nxt = S_S_RD2;
      end

      S_S_RD2: begin
        s0_nxt = kt2d_pkg::sat40(kt2d_pkg::sx40(rd_a_r) + {17'd0, mn_r});
        s3_nxt = kt2d_pkg::sat40(kt2d_pkg::sx40(rd_b_r) + {17'd0, mn_r});
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_PP, 4'd1};
        rb = {kt2d_pkg::RG_PP, 4'd4};
        state_nxt = S_S_CAP;
      end

      S_S_CAP: begin
        s1_nxt = rd_a_r;
        s2_nxt = rd_b_r;
        v48 = kt2d_pkg::sx32(lm0_r) - kt2d_pkg::sx32(x_r[0]);
        y0_nxt = v48[39:0];
        v48 = kt2d_pkg::sx32(lm1_r) - kt2d_pkg::sx32(x_r[1]);
        y1_nxt = v48[39:0];
        u_nxt = 2'd0;
        state_nxt = S_DET;
      end

      S_DET: begin
        md_a = (u_r == 2'd0) ? s0_r : s1_r;
        md_b = (u_r == 2'd0) ? s3_r : s2_r;
        if (md_done) begin
          if (u_r == 2'd0) begin
            t_nxt = md_res;
            u_nxt = 2'd1;
          end else begin
            det_v = kt2d_pkg::sat40(kt2d_pkg::sx40(t_r) - kt2d_pkg::sx40(md_res));
            det_nxt = det_v;
            u_nxt = 2'd0;
            e_nxt = 4'd0;
            // A singular or indefinite innovation leaves the prediction as is.
            state_nxt = (det_v <= 40'sd0) ? S_CPY_RD : S_INV;
          end
        end
      end

      S_INV: begin
        md_b = det_r;
        case (u_r)
          2'd0: md_a = s3_r;
          2'd1: begin md_a = s1_r; md_req.neg_a = 1'b1; end
          2'd2: begin md_a = s2_r; md_req.neg_a = 1'b1; end
          default: md_a = s0_r;
        endcase
        if (md_done) begin
          case (u_r)
            2'd0:    inv0_nxt = md_res;
            2'd1:    inv1_nxt = md_res;
            2'd2:    inv2_nxt = md_res;
            default: inv3_nxt = md_res;
          endcase
          u_nxt = u_r + 2'd1;
          if (u_r == 2'd3) begin
            e_nxt = 4'd0;
            state_nxt = S_K_RD;
          end
        end
      end

      S_K_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_PP, e_r[2:1], 2'd0};
        rb = {kt2d_pkg::RG_PP, e_r[2:1], 2'd1};
        u_nxt = 2'd0;
        state_nxt = S_K_MUL;
      end

      S_K_MUL: begin
        if (u_r == 2'd0) begin
          md_a = rd_a_r;
          md_b = e_r[0] ? inv1_r : inv0_r;
        end else begin
          md_a = rd_b_r;
          md_b = e_r[0] ? inv3_r : inv2_r;
        end
        if (md_done) begin
          if (u_r == 2'd0) begin
            t_nxt = md_res;
            u_nxt = 2'd1;
          end else begin
            mem_we = 1'b1;
            mem_wa = {kt2d_pkg::RG_K, 1'b0, e_r[2:0]};
            mem_wd = kt2d_pkg::sat40(kt2d_pkg::sx40(t_r) + kt2d_pkg::sx40(md_res));
            e_nxt = (e_r == 4'd7) ? 4'd0 : e_r + 4'd1;
            state_nxt = (e_r == 4'd7) ? S_X_RD : S_K_RD;
          end
        end
      end

      S_X_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_K, 1'b0, e_r[1:0], 1'b0};
        rb = {kt2d_pkg::RG_K, 1'b0, e_r[1:0], 1'b1};
        u_nxt = 2'd0;
        state_nxt = S_X_MUL;
      end

      S_X_MUL: begin
        md_a = (u_r == 2'd0) ? rd_a_r : rd_b_r;
        md_b = (u_r == 2'd0) ? y0_r : y1_r;
        if (md_done) begin
          if (u_r == 2'd0) begin
            t_nxt = md_res;
            u_nxt = 2'd1;
          end else begin
            x_nxt[e_r[1:0]] = kt2d_pkg::sat32(kt2d_pkg::sx32(x_r[e_r[1:0]]) +
                                             kt2d_pkg::sx40(t_r) + kt2d_pkg::sx40(md_res));
            e_nxt = (e_r == 4'd3) ? 4'd0 : e_r + 4'd1;
            state_nxt = (e_r == 4'd3) ? S_NP_RD1 : S_X_RD;
          end
        end
      end

      S_NP_RD1: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_K, 1'b0, e_r[3:2], 1'b0};
        rb = {kt2d_pkg::RG_PP, 2'd0, e_r[1:0]};
        state_nxt = S_NP_M1;
      end

      S_NP_M1: begin
        md_a = rd_a_r;
        md_b = rd_b_r;
        if (md_done) begin
          t_nxt = md_res;
          state_nxt = S_NP_RD2;
        end
      end

      S_NP_RD2: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_K, 1'b0, e_r[3:2], 1'b1};
        rb = {kt2d_pkg::RG_PP, 2'd1, e_r[1:0]};
        state_nxt = S_NP_M2;
      end

      S_NP_M2: begin
        md_a = rd_a_r;
        md_b = rd_b_r;
        if (md_done) begin
          t2_nxt = md_res;
          state_nxt = S_NP_RD3;
        end
      end

      S_NP_RD3: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_PP, e_r};
        rb = {kt2d_pkg::RG_PP, e_r};
        state_nxt = S_NP_WR;
      end

      S_NP_WR: begin
        mem_we = 1'b1;
        mem_wa = {kt2d_pkg::RG_P, e_r};
        mem_wd = kt2d_pkg::sat40(kt2d_pkg::sx40(rd_a_r) - kt2d_pkg::sx40(t_r) -
                                 kt2d_pkg::sx40(t2_r));
        e_nxt = e_r + 4'd1;
        state_nxt = (e_r == 4'd15) ? S_DONE : S_NP_RD1;
      end

      S_CPY_RD: begin
        mem_re = 1'b1;
        ra = {kt2d_pkg::RG_PP, e_r};
        rb = {kt2d_pkg::RG_PP, e_r};
        state_nxt = S_CPY_WR;
      end

      S_CPY_WR: begin
        mem_we = 1'b1;
        mem_wa = {kt2d_pkg::RG_P, e_r};
        mem_wd = rd_a_r;
        e_nxt = e_r + 4'd1;
        state_nxt = (e_r == 4'd15) ? S_DONE : S_CPY_RD;
      end

      S_DONE: begin
        // The estimate beat waits here only while the previous one is unread.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          opx_nxt = x_r[0];
          opy_nxt = x_r[1];
          ovx_nxt = x_r[2];
          ovy_nxt = x_r[3];
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      e_r         <= 4'd0;
      u_r         <= 2'd0;
      md_busy_r   <= 1'b0;
      init_r      <= 1'b0;
      seed_upd_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pn_r        <= kt2d_pkg::PROC_NOISE_RST;
      mn_r        <= kt2d_pkg::MEAS_NOISE_RST;
      ic_r        <= kt2d_pkg::INIT_COV_RST;
      for (int k = 0; k < 4; k++) x_r[k] <= '0;
      lm0_r       <= '0;
      lm1_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      e_r         <= e_nxt;
      u_r         <= u_nxt;
      md_busy_r   <= md_busy_nxt;
      init_r      <= init_nxt;
      seed_upd_r  <= seed_upd_nxt;
      out_valid_r <= out_valid_nxt;
      pn_r        <= pn_nxt;
      mn_r        <= mn_nxt;
      ic_r        <= ic_nxt;
      for (int k = 0; k < 4; k++) x_r[k] <= x_nxt[k];
      lm0_r       <= lm0_nxt;
      lm1_r       <= lm1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;  s1_r <= s1_nxt;  s2_r <= s2_nxt;  s3_r <= s3_nxt;
    det_r <= det_nxt;
    inv0_r <= inv0_nxt;  inv1_r <= inv1_nxt;  inv2_r <= inv2_nxt;  inv3_r <= inv3_nxt;
    t_r <= t_nxt;  t2_r <= t2_nxt;  y0_r <= y0_nxt;  y1_r <= y1_nxt;
    opx_r <= opx_nxt;  opy_r <= opy_nxt;  ovx_r <= ovx_nxt;  ovy_r <= ovy_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.est_pos_x = opx_r;
  assign out_ch.est_pos_y = opy_r;
  assign out_ch.est_vel_x = ovx_r;
  assign out_ch.est_vel_y = ovy_r;

`ifndef SYNTH
  // The arithmetic unit only reports completion of a request it was given.
  a_md_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> md_busy_r)
    else $error("muldiv completion without an outstanding request");

  // The sequencer never reads an entry in the cycle it is written.
  a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != ra && mem_wa != rb))
    else $error("scratch memory read and write collide");

  // An estimate beat is only raised from the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == S_DONE))
    else $error("estimate beat raised outside completion");

  // Every accepted beat starts work; the sequencer does not stay idle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted beat dropped");
`endif

endmodule
